[rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Holds the command format that travels from the match front end to the
// output sequencer, and the configuration register indexes.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Most result bytes one text byte can cause (replacement or flush)
  localparam int CMD_SLOTS = 8;
  localparam int SLOT_W    = $clog2(CMD_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int CFG_W     = 64;
  localparam int LEN_W     = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  // One queued command: bytes to send in slot order, how many, end of text
  typedef struct packed {
    logic [CMD_SLOTS-1:0][7:0] data;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } cmd_t;

endpackage

[rtl/sfr_front.sv]
// ----------------------------------------------------------------------------
// sfr_front: pending window and pattern match
// Accepts one text byte per request, compares window plus byte against the
// pattern, and pushes one command describing the result bytes.
// ----------------------------------------------------------------------------
module sfr_front #(
  parameter int PATTERN_MAX = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_final_byte,
  input  logic [63:0]                   pattern_bytes,
  input  logic [$clog2(PATTERN_MAX):0]  pattern_len,
  input  logic [63:0]                   repl_bytes,
  input  logic [sfr_pkg::CNT_W-1:0]     repl_len,
  input  logic                          fifo_full,
  output logic                          push,
  output sfr_pkg::cmd_t                 cmd
);
  import sfr_pkg::*;

  localparam int CW  = $clog2(PATTERN_MAX);
  localparam int WIN = PATTERN_MAX - 1;

  logic [7:0]    win_r   [WIN];
  logic [7:0]    win_nxt [WIN];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    cand [PATTERN_MAX];
  logic [CW:0]   n1;
  logic          match, hit, emit_one;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;

  // Build the candidate: pending bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      cand[i] = (i < int'(cnt_r)) ? win_r[i] : in_text_byte;
    end
    cand[WIN] = in_text_byte;
    n1 = {1'b0, cnt_r} + (CW+1)'(1);
  end

  // Compare candidate against the pattern
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < int'(pattern_len) && cand[i] != pattern_bytes[8*i +: 8]) begin
        match = 1'b0;
      end
    end
    hit      = match && (n1 == pattern_len);
    emit_one = (n1 >= pattern_len);
  end

  // Form the command and the next window
  always_comb begin
    cmd.last = in_final_byte;
    if (hit) begin
      cmd.data  = repl_bytes;
      cmd.count = repl_len;
    end else begin
      cmd.data = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        cmd.data[i] = cand[i];
      end
      if (in_final_byte) begin
        cmd.count = CNT_W'(n1);
      end else if (emit_one) begin
        cmd.count = CNT_W'(1);
      end else begin
        cmd.count = '0;
      end
    end

    for (int i = 0; i < WIN; i++) begin
      win_nxt[i] = emit_one ? cand[i+1] : cand[i];
    end
    if (hit || in_final_byte) begin
      cnt_nxt = '0;
    end else if (emit_one) begin
      cnt_nxt = CW'(n1 - (CW+1)'(1));
    end else begin
      cnt_nxt = CW'(n1);
    end
  end

  // Hold window bytes; advance on each accepted request
  always_ff @(posedge clk) begin
    if (push) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/sfr_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// sfr_cmd_fifo: two-entry command queue
// Decouples the match front end from the output sequencer.
// ----------------------------------------------------------------------------
module sfr_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output sfr_pkg::cmd_t head
);
  import sfr_pkg::*;

  cmd_t       entries_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = entries_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/sfr_back.sv]
// ----------------------------------------------------------------------------
// sfr_back: output sequencer
// Walks the head command one byte per cycle into the output register while the receiver accepts results.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  sfr_pkg::cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_out_byte,
  output logic          out_out_valid,
  output logic          out_out_last
);
  import sfr_pkg::*;

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              bval_r, bval_nxt;
  logic              last_r, last_nxt;
  logic              can_load, empty_cmd, final_slot;

  assign can_load   = !valid_r || out_ready;
  assign empty_cmd  = (cmd.count == '0);
  assign final_slot = ({1'b0, idx_r} == cmd.count - CNT_W'(1));

  // Select the next result and decide when the head command is done
  always_comb begin
    pop       = 1'b0;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_ready;
    byte_nxt  = byte_r;
    bval_nxt  = bval_r;
    last_nxt  = last_r;
    if (cmd_valid && empty_cmd && !cmd.last) begin
      // drop: nothing to send for this item
      pop = 1'b1;
    end else if (cmd_valid && can_load) begin
      valid_nxt = 1'b1;
      if (empty_cmd) begin
        byte_nxt = 8'd0;
        bval_nxt = 1'b0;
        last_nxt = 1'b1;
        pop      = 1'b1;
      end else begin
        byte_nxt = cmd.data[idx_r];
        bval_nxt = 1'b1;
        last_nxt = cmd.last && final_slot;
        pop      = final_slot;
        idx_nxt  = final_slot ? '0 : idx_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    bval_r <= bval_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_out_byte  = byte_r;
  assign out_out_valid = bval_r;
  assign out_out_last  = last_r;

endmodule

[rtl/stream_find_and_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_and_replace: streaming byte find-and-replace
// Replaces leftmost non-overlapping occurrences of a configured pattern of
// up to PATTERN_MAX bytes with a replacement of up to eight bytes.
//
// Input channel (in_valid/in_ready): one text byte per request, with
// in_final_byte set on the last byte of the text. Result channel
// (out_valid/out_ready): one byte per request; out_out_valid is 0 only on an
// empty end-of-text marker, and out_out_last flags the last result of a text.
// Configuration: write cfg_data to register cfg_index when cfg_we is high,
// only while the block is idle.
//
// The first result of a byte passes through the command queue and then the
// output register before out_valid rises.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver is ready; a byte with more results holds the output
// sequencer until all are sent; the two-entry queue then fills and drops in_ready.
// Reset clears the window, the queue and the output register, and loads the
// register defaults (pattern length 1, empty replacement). When the receiver
// stalls, the output holds and the queue absorbs two more bytes.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
  parameter int PATTERN_MAX = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_text_byte,
  input  logic                      in_final_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_out_byte,
  output logic                      out_out_valid,
  output logic                      out_out_last,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0] cfg_data
);
  import sfr_pkg::*;

  localparam int CW = $clog2(PATTERN_MAX);

  logic [CFG_W-1:0] pattern_bytes_r, repl_bytes_r;
  logic [LEN_W-1:0] pattern_len_r, repl_len_r;
  logic [CW:0]      plen_eff;
  logic [CNT_W-1:0] rlen_eff;
  logic             fifo_full, fifo_not_empty, push, pop;
  cmd_t             push_cmd, head_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r <= '0;
      pattern_len_r   <= LEN_W'(1);
      repl_bytes_r    <= '0;
      repl_len_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:      pattern_bytes_r <= cfg_data;
        CFG_PATTERN_LENGTH:     pattern_len_r   <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  repl_bytes_r    <= cfg_data;
        CFG_REPLACEMENT_LENGTH: repl_len_r      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp lengths to their usable ranges
  always_comb begin
    if (pattern_len_r == '0) begin
      plen_eff = (CW+1)'(1);
    end else if (int'(pattern_len_r) > PATTERN_MAX) begin
      plen_eff = (CW+1)'(PATTERN_MAX);
    end else begin
      plen_eff = (CW+1)'(pattern_len_r);
    end
    if (int'(repl_len_r) > CMD_SLOTS) begin
      rlen_eff = CNT_W'(CMD_SLOTS);
    end else begin
      rlen_eff = CNT_W'(repl_len_r);
    end
  end

  sfr_front #(.PATTERN_MAX(PATTERN_MAX)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .pattern_bytes (pattern_bytes_r),
    .pattern_len   (plen_eff),
    .repl_bytes    (repl_bytes_r),
    .repl_len      (rlen_eff),
    .fifo_full     (fifo_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  sfr_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (fifo_full),
    .not_empty (fifo_not_empty),
    .head      (head_cmd)
  );

  sfr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (fifo_not_empty),
    .cmd           (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_out_valid (out_out_valid),
    .out_out_last  (out_out_last)
  );

  // An empty result is only ever the end-of-text marker
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_last)
    else $error("empty result without last flag");

  // An empty result carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_byte == 8'd0)
    else $error("empty result with nonzero byte");

  // No pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> fifo_not_empty)
    else $error("command queue popped while empty");

  // Output register is clear right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
